>>> src/tiir_pkg.sv
package tiir_pkg;

  localparam int MAX_TAPS   = 256;
  localparam int TAP_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W      = $clog2(MAX_TAPS + 1);
  localparam int TAPS_W     = 9;
  localparam int CMP_W      = (CNT_W > TAPS_W) ? CNT_W : TAPS_W;

  localparam int FUNC_W     = 2;
  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 8;
  localparam int COEF_W     = 18;
  localparam int DLY_W      = 40;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int SUM_W      = DLY_W + 1;
  localparam int FRAC_SHIFT = 14;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = TAPS_W;

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_FF  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WR_FB  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TAPS     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 4'd1;

  typedef struct packed {
    logic mul_en;   // load product register
    logic mul_fb;   // feedback coefficient times output, else feedforward times input
    logic mul_zero; // load zero product
    logic acc_en;   // load accumulator
    logic add_z;    // include the delay operand in sums
  } tiir_mac_ctl_t;

endpackage

>>> src/tiir_mac.sv
module tiir_mac import tiir_pkg::*; (
  input  logic                        clk,
  input  tiir_mac_ctl_t               ctl,
  input  logic signed [COEF_W-1:0]    ff_coef,
  input  logic signed [COEF_W-1:0]    fb_coef,
  input  logic signed [SAMPLE_W-1:0]  x,
  input  logic signed [SAMPLE_W-1:0]  y,
  input  logic signed [DLY_W-1:0]     z,
  output logic signed [DLY_W-1:0]     dly_new,
  output logic signed [SAMPLE_W-1:0]  y_out,
  output logic                        y_sat
);

  localparam int YQ_W = SUM_W - FRAC_SHIFT;
  localparam logic signed [YQ_W-1:0] YQ_MAX = YQ_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [YQ_W-1:0] YQ_MIN = YQ_W'(-(2 ** (SAMPLE_W - 1)));
  localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(2 ** (FRAC_SHIFT - 1));

  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [DLY_W-1:0]    acc_r;
  logic signed [DLY_W-1:0]    acc_nxt;
  logic signed [COEF_W-1:0]   op_c;
  logic signed [SAMPLE_W-1:0] op_s;
  logic signed [DLY_W-1:0]    z_sel;
  logic signed [DLY_W-1:0]    prod_ext;
  logic signed [SUM_W-1:0]    ysum;
  logic signed [SUM_W-1:0]    yrnd;
  logic signed [YQ_W-1:0]     yq;

  always_comb begin
    op_c     = ctl.mul_fb ? fb_coef : ff_coef;
    op_s     = ctl.mul_fb ? y : x;
    if (ctl.mul_zero) begin
      prod_nxt = '0;
    end else begin
      prod_nxt = op_c * op_s;
    end
    z_sel    = ctl.add_z ? z : '0;
    prod_ext = {{(DLY_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    acc_nxt  = z_sel + prod_ext;
    // wrap to the delay width: all delay arithmetic is modulo 2^DLY_W
    dly_new  = acc_r - prod_ext;
  end

  // output: exact sum, round half up, saturate
  always_comb begin
    ysum = {z_sel[DLY_W-1], z_sel} + {{(SUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    yrnd = ysum + RND_BIAS;
    yq   = yrnd[SUM_W-1:FRAC_SHIFT];
    if (yq > YQ_MAX) begin
      y_out = {1'b0, {(SAMPLE_W - 1){1'b1}}};
      y_sat = 1'b1;
    end else if (yq < YQ_MIN) begin
      y_out = {1'b1, {(SAMPLE_W - 1){1'b0}}};
      y_sat = 1'b1;
    end else begin
      y_out = yq[SAMPLE_W-1:0];
      y_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

>>> src/transposed_iir_fir_filter.sv
// Transposed direct form II filter (IIR, or FIR with feedback off) on one shared
// 18x16 multiplier. A sample item returns one result: first b[0]*x and the rounded
// output, then for each tap past the first two products (b*x, then a*y) through the
// single multiplier, also in FIR mode, where a*y is loaded as zero; then the last
// delay is written. The block takes no new item until it has finished the last one.
// Coefficient writes and clears give no result. The delay store carries a valid
// bit per entry, so reset and clear act at once with no clearing pass. A finished
// result waits in an output register; the block holds off new items until that
// register is free to take the next result.
module transposed_iir_fir_filter import tiir_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [FUNC_W-1:0]           in_func,
  input  logic signed [SAMPLE_W-1:0]  in_sample_in,
  input  logic [IDX_W-1:0]            in_coef_index,
  input  logic signed [COEF_W-1:0]    in_coef_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_sample_out,
  output logic                        out_saturated,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y_MUL,
    ST_Y_ACC,
    ST_MUL_B,
    ST_MUL_A,
    ST_WR_LAST,
    ST_DONE
  } state_t;

  state_t                     state_r;
  logic [TAPS_W-1:0]          cfg_taps_r;
  logic                       cfg_fb_r;
  logic [TAP_W-1:0]           k_r;
  logic [TAP_W-1:0]           last_r;
  logic [TAP_W-1:0]           last_nxt;
  logic                       fb_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic                       sat_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_sat_r;

  logic signed [COEF_W-1:0]   ff_mem [MAX_TAPS];
  logic signed [COEF_W-1:0]   fb_mem [MAX_TAPS];
  logic signed [DLY_W-1:0]    dly_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        dly_vld_r;
  logic signed [COEF_W-1:0]   ff_rd_r;
  logic signed [COEF_W-1:0]   fb_rd_r;
  logic signed [DLY_W-1:0]    dly_rd_r;

  logic                       in_acc;
  logic                       coef_ok;
  logic [TAP_W-1:0]           coef_wa;
  logic                       rd_en;
  logic [TAP_W-1:0]           rd_addr;
  logic                       dly_we;
  logic [TAP_W-1:0]           dly_wa;
  logic [CMP_W-1:0]           taps_ext;
  tiir_mac_ctl_t              mac_ctl;
  logic signed [DLY_W-1:0]    mac_dly_new;
  logic signed [SAMPLE_W-1:0] mac_y;
  logic                       mac_sat;

  assign in_ready       = (state_r == ST_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  assign coef_ok = CMP_W'(in_coef_index) < CMP_W'(MAX_TAPS);
  assign coef_wa = TAP_W'(in_coef_index);

  // clamp the tap count to 1..MAX_TAPS, keep the index of the last tap
  always_comb begin
    taps_ext = CMP_W'(cfg_taps_r);
    if (taps_ext == '0) begin
      last_nxt = '0;
    end else if (taps_ext > CMP_W'(MAX_TAPS)) begin
      last_nxt = TAP_W'(MAX_TAPS - 1);
    end else begin
      last_nxt = TAP_W'(taps_ext - CMP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_taps_r <= TAPS_W'(1);
      cfg_fb_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TAPS:     cfg_taps_r <= cfg_data;
        REG_FEEDBACK: cfg_fb_r   <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // tap k: MUL_B forms b[k]*x and writes z[k-2]; MUL_A forms a[k]*y,
  // accumulates z[k+1-1] and fetches tap k+1
  always_comb begin
    mac_ctl = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    dly_we  = 1'b0;
    dly_wa  = '0;
    unique case (state_r)
      ST_IDLE: begin
        rd_en = in_valid && (in_func == FUNC_SAMPLE);
      end
      ST_Y_MUL: begin
        mac_ctl.mul_en = 1'b1;
      end
      ST_Y_ACC: begin
        mac_ctl.add_z = (last_r != '0);
        rd_en         = (last_r != '0);
        rd_addr       = TAP_W'(1);
      end
      ST_MUL_B: begin
        mac_ctl.mul_en = 1'b1;
        dly_we         = (k_r != TAP_W'(1));
        dly_wa         = k_r - TAP_W'(2);
      end
      ST_MUL_A: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.mul_fb   = 1'b1;
        mac_ctl.mul_zero = !fb_r;
        mac_ctl.acc_en   = 1'b1;
        mac_ctl.add_z    = (k_r != last_r);
        rd_en            = (k_r != last_r);
        rd_addr          = k_r + TAP_W'(1);
      end
      ST_WR_LAST: begin
        dly_we = 1'b1;
        dly_wa = k_r - TAP_W'(1);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_func == FUNC_WR_FF) && coef_ok) begin
      ff_mem[coef_wa] <= in_coef_value;
    end
    if (in_acc && (in_func == FUNC_WR_FB) && coef_ok) begin
      fb_mem[coef_wa] <= in_coef_value;
    end
    if (dly_we) begin
      dly_mem[dly_wa] <= mac_dly_new;
    end
    if (rd_en) begin
      ff_rd_r  <= ff_mem[rd_addr];
      fb_rd_r  <= fb_mem[rd_addr];
      dly_rd_r <= dly_vld_r[rd_addr] ? dly_mem[rd_addr] : '0;
    end
  end

  // an entry never written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
    end else if (in_acc && (in_func == FUNC_CLEAR)) begin
      dly_vld_r <= '0;
    end else if (dly_we) begin
      dly_vld_r[dly_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && (in_func == FUNC_SAMPLE)) begin
            x_r     <= in_sample_in;
            last_r  <= last_nxt;
            fb_r    <= cfg_fb_r;
            state_r <= ST_Y_MUL;
          end
        end
        ST_Y_MUL: begin
          state_r <= ST_Y_ACC;
        end
        ST_Y_ACC: begin
          y_r     <= mac_y;
          sat_r   <= mac_sat;
          k_r     <= TAP_W'(1);
          state_r <= (last_r == '0) ? ST_DONE : ST_MUL_B;
        end
        ST_MUL_B: begin
          state_r <= ST_MUL_A;
        end
        ST_MUL_A: begin
          if (k_r == last_r) begin
            state_r <= ST_WR_LAST;
          end else begin
            k_r     <= k_r + TAP_W'(1);
            state_r <= ST_MUL_B;
          end
        end
        ST_WR_LAST: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= y_r;
            out_sat_r    <= sat_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  tiir_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .ff_coef (ff_rd_r),
    .fb_coef (fb_rd_r),
    .x       (x_r),
    .y       (y_r),
    .z       (dly_rd_r),
    .dly_new (mac_dly_new),
    .y_out   (mac_y),
    .y_sat   (mac_sat)
  );

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done state");

  a_dly_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    dly_we |-> (dly_wa < last_r))
    else $error("delay write beyond the last tap");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_B || state_r == ST_MUL_A) |-> (k_r != '0 && k_r <= last_r))
    else $error("tap counter out of range");

  a_no_result_for_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func != FUNC_SAMPLE) |=> (state_r == ST_IDLE))
    else $error("non-sample item started a computation");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tiir_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 9;
  localparam int STUCK_LIMIT  = 4000;
  localparam int LONG_STALL   = 400;
  localparam int SAMPLE_ITEMS = 540;
  localparam int QUIET_ITEMS  = 150;
  localparam int MAX_REPORTS  = 30;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0]   COEF_ONE   = COEF_W'(1 << FRAC_SHIFT);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       clipped;
  } filter_result_t;

  class filter_scoreboard;
    logic signed [COEF_W-1:0] ff_coef    [MAX_TAPS];
    logic signed [COEF_W-1:0] fb_coef    [MAX_TAPS];
    logic signed [DLY_W-1:0]  delay_line [MAX_TAPS];
    logic [TAPS_W-1:0]        taps_reg;
    bit                       feedback_on;
    filter_result_t           expected_outputs[$];
    int errors, n_samples, n_clipped, n_coef_writes, n_clears, n_reg_writes;

    function new();
      foreach (delay_line[i]) begin
        ff_coef[i]    = '0;
        fb_coef[i]    = '0;
        delay_line[i] = '0;
      end
      taps_reg    = 1;
      feedback_on = 0;
    endfunction

    static function int active_taps(logic [TAPS_W-1:0] t);
      if (t == 0) return 1;
      if (t > MAX_TAPS) return MAX_TAPS;
      return int'(t);
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // One sample through the transposed structure: output first, then shift the delays.
    function filter_result_t filter_sample(logic signed [SAMPLE_W-1:0] x);
      filter_result_t res;
      int n_taps, n;
      longint acc, y, v;
      n_taps = active_taps(taps_reg);
      acc = longint'(ff_coef[0]) * longint'(x);
      if (n_taps > 1) acc += longint'(delay_line[0]);
      y = (acc + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      res.clipped = 1'b0;
      if (y > longint'(SAMPLE_MAX)) begin
        y = longint'(SAMPLE_MAX);
        res.clipped = 1'b1;
      end else if (y < longint'(SAMPLE_MIN)) begin
        y = longint'(SAMPLE_MIN);
        res.clipped = 1'b1;
      end
      res.value = y[SAMPLE_W-1:0];
      for (n = 0; n < n_taps - 1; n++) begin
        v = longint'(ff_coef[n+1]) * longint'(x);
        if (n + 2 < n_taps) v += longint'(delay_line[n+1]);
        if (feedback_on) v -= longint'(fb_coef[n+1]) * y;
        delay_line[n] = v[DLY_W-1:0];
      end
      return res;
    endfunction

    function void note_item(logic [FUNC_W-1:0] func, logic signed [SAMPLE_W-1:0] x,
                            logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] cv);
      case (func)
        FUNC_SAMPLE: begin
          expected_outputs.push_back(filter_sample(x));
          n_samples++;
        end
        FUNC_WR_FF: begin
          if (idx < MAX_TAPS) ff_coef[idx] = cv;
          n_coef_writes++;
        end
        FUNC_WR_FB: begin
          if (idx < MAX_TAPS) fb_coef[idx] = cv;
          n_coef_writes++;
        end
        default: begin
          foreach (delay_line[i]) delay_line[i] = '0;
          n_clears++;
        end
      endcase
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_TAPS) taps_reg = data[TAPS_W-1:0];
      else if (index == REG_FEEDBACK) feedback_on = data[0];
      n_reg_writes++;
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] value, logic clipped);
      filter_result_t want;
      if (expected_outputs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result %0d arrived with no sample waiting", $time, value);
        return;
      end
      want = expected_outputs.pop_front();
      if (want.clipped) n_clipped++;
      if (value !== want.value) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: sample_out expected %0d actual %0d", $time, want.value, value);
      end
      if (clipped !== want.clipped) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: saturated expected %0b actual %0b", $time, want.clipped, clipped);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [FUNC_W-1:0]          in_func;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic [IDX_W-1:0]           in_coef_index;
  logic signed [COEF_W-1:0]   in_coef_value;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_saturated;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  filter_scoreboard sb = new();

  bit quiet;
  bit sender_gaps;
  bit long_stall_req;
  bit ff_loaded [MAX_TAPS];
  bit fb_loaded [MAX_TAPS];
  int sample_items;
  int settings;
  int stuck_cycles;

  transposed_iir_fir_filter u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_sample_in   (in_sample_in),
    .in_coef_index  (in_coef_index),
    .in_coef_value  (in_coef_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_sample_out, out_saturated);
      if (in_valid && in_ready)
        sb.note_item(in_func, in_sample_in, in_coef_index, in_coef_value);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_stall_req) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_stall_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_W'($urandom);
      1:       return COEF_MAX;
      2:       return COEF_MIN;
      default: return COEF_W'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic signed [SAMPLE_W-1:0] x,
                           input logic [IDX_W-1:0] idx, input logic signed [COEF_W-1:0] cv);
    if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_sample_in  <= x;
    in_coef_index <= idx;
    in_coef_value <= cv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    send_item(FUNC_SAMPLE, x, IDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_clear();
    send_item(FUNC_CLEAR, SAMPLE_W'($urandom), IDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic load_coef(input logic [FUNC_W-1:0] func, input int idx,
                           input logic signed [COEF_W-1:0] cv);
    send_item(func, SAMPLE_W'($urandom), IDX_W'(idx), cv);
    if (func == FUNC_WR_FF) ff_loaded[idx] = 1;
    else fb_loaded[idx] = 1;
  endtask

  // Drop valid and hold until every sample has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // New tap count and mode, then load each coefficient the samples will read that is not yet loaded.
  task automatic configure(input logic [TAPS_W-1:0] taps, input bit fb);
    logic [CFG_DATA_W-1:0] fb_word;
    int n, i;
    fb_word    = CFG_DATA_W'($urandom);
    fb_word[0] = fb;
    wait_drained();
    set_reg(REG_TAPS, taps);
    set_reg(REG_FEEDBACK, fb_word);
    if ($urandom_range(0, 3) == 0)
      set_reg(CFG_IDX_W'($urandom_range(int'(REG_FEEDBACK) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    n = filter_scoreboard::active_taps(taps);
    for (i = 0; i < n; i++) begin
      if (!ff_loaded[i]) load_coef(FUNC_WR_FF, i, rand_coef());
      if (fb && i > 0 && !fb_loaded[i]) load_coef(FUNC_WR_FB, i, rand_coef());
    end
    settings++;
  endtask

  initial begin
    logic [TAPS_W-1:0] taps;
    bit fb, big;
    int n_items, n_eff, r, idx;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= FUNC_SAMPLE;
    in_sample_in  <= '0;
    in_coef_index <= '0;
    in_coef_value <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_TAPS;
    cfg_data      <= '0;
    sender_gaps   = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single tap: full-scale products in both directions clip.
    set_reg(REG_TAPS, 1);
    set_reg(REG_FEEDBACK, 0);
    set_reg({CFG_IDX_W{1'b1}}, {CFG_DATA_W{1'b1}});
    load_coef(FUNC_WR_FF, 0, COEF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(1);
    load_coef(FUNC_WR_FF, 0, COEF_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    load_coef(FUNC_WR_FF, 0, COEF_ONE);
    send_sample(12345);
    send_sample(0);
    // A tap count of zero behaves as one tap.
    wait_drained();
    set_reg(REG_TAPS, 0);
    send_sample(-1);
    wait_drained();
    set_reg(REG_TAPS, 3);
    set_reg(REG_FEEDBACK, 1);
    load_coef(FUNC_WR_FF, 1, COEF_W'(8192));
    load_coef(FUNC_WR_FF, 2, -COEF_W'(4096));
    load_coef(FUNC_WR_FB, 1, -COEF_W'(8192));
    load_coef(FUNC_WR_FB, 2, COEF_W'(4096));
    send_sample(16384);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_clear();
    send_sample(SAMPLE_MAX);
    load_coef(FUNC_WR_FF, MAX_TAPS - 1, -COEF_W'(1));
    load_coef(FUNC_WR_FB, MAX_TAPS - 1, COEF_MAX);
    settings = 3;

    // Fill the block while results are held off, sender never pausing.
    sender_gaps = 0;
    configure(2, 0);
    long_stall_req = 1;
    repeat (30) send_sample(rand_sample());

    while (sample_items < SAMPLE_ITEMS) begin
      quiet       = sample_items >= SAMPLE_ITEMS - QUIET_ITEMS;
      sender_gaps = $urandom_range(0, 2) != 0;
      big         = 0;
      if (settings == 6) begin
        taps = MAX_TAPS;
        fb   = 0;
        big  = 1;
      end else if (settings == 12) begin
        taps = {TAPS_W{1'b1}};
        fb   = 1;
        big  = 1;
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) taps = TAPS_W'($urandom_range(9, 40));
        else if (r == 1) taps = TAPS_W'($urandom_range(0, 1));
        else taps = TAPS_W'($urandom_range(2, 8));
        fb = $urandom_range(0, 1);
      end
      configure(taps, fb);
      n_eff   = filter_scoreboard::active_taps(taps);
      n_items = big ? 6 : $urandom_range(20, 60);
      repeat (n_items) begin
        r   = $urandom_range(0, 19);
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_TAPS - 1)
                                          : $urandom_range(0, n_eff - 1);
        if (r < 2) load_coef(FUNC_WR_FF, idx, rand_coef());
        else if (r == 2) load_coef(FUNC_WR_FB, idx, rand_coef());
        else if (r == 3) send_clear();
        else send_sample(rand_sample());
        sample_items++;
      end
    end

    wait_drained();
    repeat (2 * MAX_TAPS + 8) @(posedge clk);
    $display("Covered %0d samples (%0d clipped), %0d coefficient writes, %0d clears",
             sb.n_samples, sb.n_clipped, sb.n_coef_writes, sb.n_clears);
    $display("over %0d filter settings (taps 0 to 511, FIR and IIR), %0d register writes",
             settings, sb.n_reg_writes);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
